// ===== rtl/core/ifmt_pkg.sv =====
package ifmt_pkg;

  // Digit slots of the conversion register, one nibble each
  localparam int DIG_SLOTS = 12;
  localparam int DIG_BITS  = 4 * DIG_SLOTS;

  // Conversion kinds
  localparam logic [2:0] KIND_SDEC = 3'd0;
  localparam logic [2:0] KIND_UDEC = 3'd1;
  localparam logic [2:0] KIND_OCT  = 3'd2;
  localparam logic [2:0] KIND_HEXL = 3'd3;
  localparam logic [2:0] KIND_HEXU = 3'd4;

  // Bit positions in the flag field
  localparam int FB_ALT   = 0;
  localparam int FB_ZERO  = 1;
  localparam int FB_PLUS  = 2;
  localparam int FB_LEFT  = 3;
  localparam int FB_SPACE = 4;
  localparam int FB_PREC  = 5;

  // ASCII codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_DABBLE,
    CONV_NORM
  } conv_state_t;

  typedef enum logic [1:0] {
    EMIT_IDLE,
    EMIT_PLAN,
    EMIT_RUN
  } emit_state_t;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_PFX,
    PH_ZERO,
    PH_DIG,
    PH_TRAIL
  } phase_t;

  // Captured item, as the emitter needs it
  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] flags;
    logic [5:0] width;
    logic [5:0] prec;
    logic       negative;
    logic       is_zero;
  } fmt_item_t;

  // Conversion status towards the emitter
  typedef struct packed {
    logic       done;
    logic [3:0] ndig;
  } conv_res_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UA : CH_LA;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'b0000, d};
    end else begin
      digit_char = base + {4'b0000, d} - 8'd10;
    end
  endfunction

endpackage

// ===== rtl/core/ifmt_conv.sv =====
module ifmt_conv import ifmt_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2:0]            kind,
  input  logic [VALUE_BITS-1:0] mag,
  output conv_res_t             res,
  output logic [DIG_BITS-1:0]   digits
);

  localparam int CW = $clog2(VALUE_BITS + 1);

  conv_state_t           state, state_next;
  logic [VALUE_BITS-1:0] bin, bin_next;
  logic [DIG_BITS-1:0]   bcd, bcd_next;
  logic [CW-1:0]         cnt, cnt_next;
  logic [3:0]            ndig, ndig_next;

  logic [DIG_BITS-1:0]   magx;
  logic [DIG_BITS-1:0]   hex_load;
  logic [DIG_BITS-1:0]   oct_load;
  logic [DIG_BITS-1:0]   adj;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CONV_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
    bin  <= bin_next;
    bcd  <= bcd_next;
    ndig <= ndig_next;
  end

  always_comb begin
    magx = DIG_BITS'(mag);
    for (int i = 0; i < DIG_SLOTS; i++) begin
      hex_load[4*i +: 4] = magx[4*i +: 4];
      oct_load[4*i +: 4] = {1'b0, magx[3*i +: 3]};
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end

    state_next = state;
    bin_next   = bin;
    bcd_next   = bcd;
    cnt_next   = cnt;
    ndig_next  = ndig;
    res.done   = 1'b0;

    unique case (state)
      CONV_IDLE: begin
        if (start) begin
          if (kind == KIND_SDEC || kind == KIND_UDEC) begin
            bcd_next   = '0;
            bin_next   = mag;
            cnt_next   = CW'(VALUE_BITS);
            state_next = CONV_DABBLE;
          end else begin
            bcd_next   = (kind == KIND_OCT) ? oct_load : hex_load;
            ndig_next  = 4'(DIG_SLOTS);
            state_next = CONV_NORM;
          end
        end
      end
      CONV_DABBLE: begin
        // correct every decade, then shift one bit in
        bcd_next = {adj[DIG_BITS-2:0], bin[VALUE_BITS-1]};
        bin_next = {bin[VALUE_BITS-2:0], 1'b0};
        cnt_next = cnt - CW'(1);
        if (cnt == CW'(1)) begin
          ndig_next  = 4'(DIG_SLOTS);
          state_next = CONV_NORM;
        end
      end
      CONV_NORM: begin
        // drop leading zero digits, keep at least one
        if (ndig > 4'd1 && bcd[DIG_BITS-1 -: 4] == 4'd0) begin
          bcd_next  = {bcd[DIG_BITS-5:0], 4'd0};
          ndig_next = ndig - 4'd1;
        end else begin
          res.done   = 1'b1;
          state_next = CONV_IDLE;
        end
      end
      default: state_next = CONV_IDLE;
    endcase

    res.ndig = ndig;
    digits   = bcd;
  end

endmodule

// ===== rtl/core/ifmt_emit.sv =====
module ifmt_emit import ifmt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  fmt_item_t           item,
  input  conv_res_t           conv,
  input  logic [DIG_BITS-1:0] digits,
  output logic                done,
  output logic [7:0]          ch,
  output logic                last,
  output logic                strobe
);

  emit_state_t         state, state_next;
  phase_t              phase, phase_next, nph;
  logic [5:0]          run, run_next, nrun;
  logic [5:0]          remain, remain_next;
  logic [DIG_BITS-1:0] dig_sr, dig_sr_next;
  logic [3:0]          ndig, ndig_next;
  logic [5:0]          lead_n, lead_n_next;
  logic [5:0]          zero_n, zero_n_next;
  logic [5:0]          trail_n, trail_n_next;
  logic                sgn_on, sgn_on_next;
  logic                pfx_on, pfx_on_next;
  logic [7:0]          sign_ch, sign_ch_next;
  logic [7:0]          ch_next;
  logic                last_next;
  logic                strobe_next;

  // plan terms
  logic [6:0] w7, p7, n7, i7, body, len, pad, fill;
  logic       alt_oct, pfx, sgn, pflag, upper, zp, bad, is_hex;
  logic [5:0] p_lead, p_zero, p_trail, p_total;
  logic [3:0] p_dig;
  logic       p_sgn, p_pfx;
  logic [7:0] cur_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= EMIT_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
    end
    phase   <= phase_next;
    run     <= run_next;
    remain  <= remain_next;
    dig_sr  <= dig_sr_next;
    ndig    <= ndig_next;
    lead_n  <= lead_n_next;
    zero_n  <= zero_n_next;
    trail_n <= trail_n_next;
    sgn_on  <= sgn_on_next;
    pfx_on  <= pfx_on_next;
    sign_ch <= sign_ch_next;
    ch      <= ch_next;
    last    <= last_next;
  end

  always_comb begin
    // field layout from the digit count and the flags
    pflag   = item.flags[FB_PREC];
    upper   = (item.kind == KIND_HEXU);
    is_hex  = (item.kind == KIND_HEXL) || (item.kind == KIND_HEXU);
    w7      = {1'b0, item.width};
    p7      = {1'b0, item.prec};
    n7      = {3'b000, ndig};
    alt_oct = (item.kind == KIND_OCT) && item.flags[FB_ALT] && !item.is_zero;
    pfx     = is_hex && item.flags[FB_ALT] && !item.is_zero;
    sgn     = (item.kind == KIND_SDEC) &&
              (item.negative || item.flags[FB_PLUS] || item.flags[FB_SPACE]);
    i7      = n7 + 7'(alt_oct);
    body    = (pflag && p7 > i7) ? p7 : i7;
    len     = body + 7'(sgn) + {5'b00000, pfx, 1'b0};
    pad     = (w7 > len) ? w7 - len : 7'd0;
    fill    = (w7 > len) ? w7 : len;
    zp      = item.is_zero && pflag && (item.prec == 6'd0);
    bad     = (item.kind > KIND_HEXU);

    if (bad) begin
      p_lead = '0; p_zero = '0; p_trail = '0; p_total = '0;
      p_dig = '0; p_sgn = 1'b0; p_pfx = 1'b0;
    end else if (zp) begin
      p_lead = item.width; p_zero = '0; p_trail = '0; p_total = item.width;
      p_dig = '0; p_sgn = 1'b0; p_pfx = 1'b0;
    end else begin
      p_lead  = (!item.flags[FB_LEFT] && !item.flags[FB_ZERO]) ? pad[5:0] : 6'd0;
      p_zero  = 6'(body - n7) +
                ((!item.flags[FB_LEFT] && item.flags[FB_ZERO]) ? pad[5:0] : 6'd0);
      p_trail = item.flags[FB_LEFT] ? pad[5:0] : 6'd0;
      p_total = fill[5:0];
      p_dig   = ndig;
      p_sgn   = sgn;
      p_pfx   = pfx;
    end

    // next phase and its run length
    nph = phase_t'(phase + 3'd1);
    unique case (nph)
      PH_LEAD:  nrun = lead_n;
      PH_SIGN:  nrun = {5'b00000, sgn_on};
      PH_PFX:   nrun = {4'b0000, pfx_on, 1'b0};
      PH_ZERO:  nrun = zero_n;
      PH_DIG:   nrun = {2'b00, ndig};
      PH_TRAIL: nrun = trail_n;
      default:  nrun = '0;
    endcase

    unique case (phase)
      PH_LEAD:  cur_ch = CH_SPACE;
      PH_SIGN:  cur_ch = sign_ch;
      PH_PFX:   cur_ch = (run == 6'd2) ? CH_ZERO : (upper ? CH_UX : CH_LX);
      PH_ZERO:  cur_ch = CH_ZERO;
      PH_DIG:   cur_ch = digit_char(dig_sr[DIG_BITS-1 -: 4], upper);
      PH_TRAIL: cur_ch = CH_SPACE;
      default:  cur_ch = CH_SPACE;
    endcase

    state_next   = state;
    phase_next   = phase;
    run_next     = run;
    remain_next  = remain;
    dig_sr_next  = dig_sr;
    ndig_next    = ndig;
    lead_n_next  = lead_n;
    zero_n_next  = zero_n;
    trail_n_next = trail_n;
    sgn_on_next  = sgn_on;
    pfx_on_next  = pfx_on;
    sign_ch_next = sign_ch;
    ch_next      = ch;
    last_next    = last;
    strobe_next  = 1'b0;
    done         = 1'b0;

    unique case (state)
      EMIT_IDLE: begin
        if (conv.done) begin
          dig_sr_next = digits;
          ndig_next   = conv.ndig;
          state_next  = EMIT_PLAN;
        end
      end
      EMIT_PLAN: begin
        lead_n_next  = p_lead;
        zero_n_next  = p_zero;
        trail_n_next = p_trail;
        ndig_next    = p_dig;
        sgn_on_next  = p_sgn;
        pfx_on_next  = p_pfx;
        sign_ch_next = item.negative ? CH_MINUS :
                       (item.flags[FB_PLUS] ? CH_PLUS : CH_SPACE);
        phase_next   = PH_LEAD;
        run_next     = p_lead;
        remain_next  = p_total;
        if (p_total == 6'd0) begin
          done       = 1'b1;
          state_next = EMIT_IDLE;
        end else begin
          state_next = EMIT_RUN;
        end
      end
      EMIT_RUN: begin
        if (run == 6'd0) begin
          phase_next = nph;
          run_next   = nrun;
        end else begin
          strobe_next = 1'b1;
          ch_next     = cur_ch;
          last_next   = (remain == 6'd1);
          run_next    = run - 6'd1;
          remain_next = remain - 6'd1;
          if (phase == PH_DIG) begin
            dig_sr_next = {dig_sr[DIG_BITS-5:0], 4'd0};
          end
          if (remain == 6'd1) begin
            done       = 1'b1;
            state_next = EMIT_IDLE;
          end
        end
      end
      default: state_next = EMIT_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/integer_field_formatter_top.sv =====
// Integer field formatter: turns one value into a printf-style field of
// ASCII characters (signed or unsigned decimal, octal, lower or upper hex,
// with alternate form, zero or space padding, plus or space sign, left
// adjustment and a minimum digit count). An item is taken when start is
// high and busy is low; busy then stays high until the last character has
// been issued, so only one item is in flight. Each character appears on ch
// for exactly one cycle with strobe high, and last marks the final one of
// the field; the receiver cannot hold characters off and must take each
// one as it comes. A field of zero characters gives no strobe at all.
// Steps of one item: decimal conversion runs through a bit-serial binary
// to BCD shifter, while octal and hex digits load as the item is taken;
// leading zeros are then stripped from the result and it is handed on,
// the field layout is planned, and the emitter issues one character a
// cycle, pausing without a character at each step to the next field
// section (at most five), and busy drops with the final character.
module integer_field_formatter_top import ifmt_pkg::*; #(
  parameter int MAX_WIDTH  = 63,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  kind,
  input  logic [31:0] value,
  input  logic [5:0]  format_flags,
  input  logic [5:0]  field_width,
  input  logic [5:0]  precision,
  output logic        busy,
  output logic [7:0]  ch,
  output logic        last,
  output logic        strobe
);

  logic                  accept;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic                  negative;
  fmt_item_t             item;
  conv_res_t             conv_res;
  logic [DIG_BITS-1:0]   digits;
  logic                  emit_done;

  assign accept = start && !busy;

  // Take the magnitude of a negative signed value; the most negative one
  // wraps onto itself, which is exactly its unsigned magnitude.
  assign raw      = value[VALUE_BITS-1:0];
  assign negative = (kind == KIND_SDEC) && raw[VALUE_BITS-1];
  assign mag      = negative ? (~raw + VALUE_BITS'(1)) : raw;

  // Hold the item for the emitter; saturate width and precision.
  always_ff @(posedge clk) begin
    if (accept) begin
      item.kind     <= kind;
      item.flags    <= format_flags;
      item.width    <= (field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : field_width;
      item.prec     <= (precision > 6'(MAX_WIDTH - 2)) ? 6'(MAX_WIDTH - 2) : precision;
      item.negative <= negative;
      item.is_zero  <= (raw == '0);
    end
  end

  // Busy from acceptance until the emitter has issued the last character.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (emit_done) begin
      busy <= 1'b0;
    end
  end

  ifmt_conv #(
    .VALUE_BITS(VALUE_BITS)
  ) u_conv (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .kind  (kind),
    .mag   (mag),
    .res   (conv_res),
    .digits(digits)
  );

  ifmt_emit u_emit (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .conv  (conv_res),
    .digits(digits),
    .done  (emit_done),
    .ch    (ch),
    .last  (last),
    .strobe(strobe)
  );

  // Characters only come from an item that was in flight.
  a_strobe_from_item: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("character issued with no item in flight");

  // The final character coincides with busy dropping.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("busy still high on the final character");

  // A character that is not the final one leaves the block busy.
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("busy dropped before the final character");

  // An accepted item always raises busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after acceptance");

endmodule
